// ===== rtl/hsfd_pkg.sv =====
`timescale 1ns / 1ps

package hsfd_pkg;

  // Header bytes of a status frame.
  localparam logic [7:0] HDR0   = 8'hAA;
  localparam logic [7:0] HDR1_A = 8'h55;
  localparam logic [7:0] HDR1_B = 8'h66;

  // Frame length limits.
  localparam logic [7:0] PLAIN_MIN = 8'd18;
  localparam logic [7:0] ENC_FULL  = 8'd36;

  // Byte positions inside a frame.
  localparam logic [7:0] POS_FIRST   = 8'd0;
  localparam logic [7:0] POS_SECOND  = 8'd1;
  localparam logic [7:0] POS_POWER   = 8'd3;
  localparam logic [7:0] POS_ERR     = 8'd4;
  localparam logic [7:0] POS_STEP    = 8'd5;
  localparam logic [7:0] POS_TARGET  = 8'd9;
  localparam logic [7:0] POS_GEAR    = 8'd10;
  localparam logic [7:0] POS_VOLT_A  = 8'd11;
  localparam logic [7:0] POS_VOLT_B  = 8'd12;
  localparam logic [7:0] POS_EXH_A   = 8'd13;
  localparam logic [7:0] POS_EXH_B   = 8'd14;
  localparam logic [7:0] POS_AMB_PA  = 8'd15;
  localparam logic [7:0] POS_AMB_PB  = 8'd16;
  localparam logic [7:0] POS_ERR_PLN = 8'd17;
  localparam logic [7:0] POS_AMB_EA  = 8'd32;
  localparam logic [7:0] POS_AMB_EB  = 8'd33;
  localparam logic [7:0] POS_ERR_ENC = 8'd35;
  localparam logic [7:0] POS_LAST    = 8'd35;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_HDR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         power_state;
    logic [2:0]         heater_step;
    logic               readings_valid;
    logic               encrypted;
    logic [15:0]        voltage_decivolts;
    logic signed [15:0] exhaust_temp;
    logic signed [19:0] ambient_tenths;
    logic [7:0]         fault_code;
    logic [7:0]         set_point;
    logic [7:0]         gear_setting;
  } out_item_t;

  // Everything captured from the frame so far.
  typedef struct packed {
    logic [7:0]  first_raw;
    logic        enc;
    logic        alt;
    logic        hdr_bad;
    logic [1:0]  power;
    logic [2:0]  step;
    logic [7:0]  err_main;
    logic [7:0]  err_alt;
    logic [7:0]  target;
    logic [7:0]  gear;
    logic [15:0] volt;
    logic [15:0] exh;
    logic [15:0] amb;
  } frame_state_t;

  // Repeating XOR key "password".
  function automatic logic [7:0] key_byte(input logic [2:0] idx);
    logic [7:0] k;
    case (idx)
      3'd0:    k = 8'h70;
      3'd1:    k = 8'h61;
      3'd2:    k = 8'h73;
      3'd3:    k = 8'h73;
      3'd4:    k = 8'h77;
      3'd5:    k = 8'h6F;
      3'd6:    k = 8'h72;
      default: k = 8'h64;
    endcase
    return k;
  endfunction

  function automatic logic hdr_ok(input logic [7:0] b0, input logic [7:0] b1);
    return (b0 == HDR0) && ((b1 == HDR1_A) || (b1 == HDR1_B));
  endfunction

endpackage

// ===== rtl/hsfd_stream_if.sv =====
`timescale 1ns / 1ps

interface hsfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hsfd_capture.sv =====
`timescale 1ns / 1ps

module hsfd_capture
  import hsfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 48,
  parameter int CNT_W = $clog2(BUFFER_BYTES + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       frame_byte,
  input  logic             end_of_frame,
  output frame_state_t     state_nxt,
  output logic [CNT_W-1:0] len_nxt
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES + 1);

  frame_state_t     state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       idx;
  logic [7:0]       dec;
  logic [7:0]       h0;
  logic [7:0]       h1;
  logic             enc_hdr;

  assign idx = 8'(cnt_r);
  assign dec = state_r.enc ? (frame_byte ^ key_byte(cnt_r[2:0])) : frame_byte;
  assign len_nxt = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // Header check on the second byte: raw first, then with the key applied.
  assign enc_hdr = !hdr_ok(state_r.first_raw, frame_byte);
  assign h0 = enc_hdr ? (state_r.first_raw ^ key_byte(3'd0)) : state_r.first_raw;
  assign h1 = enc_hdr ? (frame_byte ^ key_byte(3'd1)) : frame_byte;

  always_comb begin
    state_nxt = state_r;
    if (idx == POS_FIRST) begin
      state_nxt = '0;
      state_nxt.first_raw = frame_byte;
    end else if (idx == POS_SECOND) begin
      state_nxt.enc     = enc_hdr;
      state_nxt.hdr_bad = !hdr_ok(h0, h1);
      state_nxt.alt     = (h1 == HDR1_B);
    end else if (idx <= POS_LAST) begin
      case (idx)
        POS_POWER:  state_nxt.power = (dec inside {[8'd1:8'd3]}) ? dec[1:0] : 2'd0;
        POS_ERR:    state_nxt.err_main = dec;
        POS_STEP:   state_nxt.step = (dec inside {[8'd1:8'd4]}) ? dec[2:0] : 3'd0;
        POS_TARGET: state_nxt.target = dec;
        POS_GEAR:   state_nxt.gear = dec;
        default: begin
          if (!state_r.enc) begin
            // Plain frames are little endian.
            case (idx)
              POS_VOLT_A:  state_nxt.volt[7:0] = dec;
              POS_VOLT_B:  state_nxt.volt[15:8] = dec;
              POS_EXH_A:   state_nxt.exh[7:0] = dec;
              POS_EXH_B:   state_nxt.exh[15:8] = dec;
              POS_AMB_PA:  state_nxt.amb[7:0] = dec;
              POS_AMB_PB:  state_nxt.amb[15:8] = dec;
              POS_ERR_PLN: state_nxt.err_alt = dec;
              default:     state_nxt.err_alt = state_r.err_alt;
            endcase
          end else begin
            // Encrypted frames are big endian.
            case (idx)
              POS_VOLT_A:  state_nxt.volt[15:8] = dec;
              POS_VOLT_B:  state_nxt.volt[7:0] = dec;
              POS_EXH_A:   state_nxt.exh[15:8] = dec;
              POS_EXH_B:   state_nxt.exh[7:0] = dec;
              POS_AMB_EA:  state_nxt.amb[15:8] = dec;
              POS_AMB_EB:  state_nxt.amb[7:0] = dec;
              POS_ERR_ENC: state_nxt.err_alt = dec;
              default:     state_nxt.err_alt = state_r.err_alt;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      cnt_r   <= end_of_frame ? '0 : len_nxt;
    end
  end

endmodule

// ===== rtl/hsfd_format.sv =====
`timescale 1ns / 1ps

module hsfd_format
  import hsfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 48,
  parameter int CNT_W = $clog2(BUFFER_BYTES + 2)
) (
  input  frame_state_t     frame,
  input  logic [CNT_W-1:0] len,
  output out_item_t        result
);

  localparam logic [7:0] BUF_LIMIT = 8'(BUFFER_BYTES);

  logic [7:0]         len8;
  status_t            status;
  logic               valid;
  logic signed [19:0] amb_ext;
  logic signed [19:0] amb_x10;

  assign len8    = 8'(len);
  assign amb_ext = {{4{frame.amb[15]}}, frame.amb};
  // Plain frames carry whole degrees: times ten as two shifts and an add.
  assign amb_x10 = (amb_ext <<< 3) + (amb_ext <<< 1);

  always_comb begin
    if (len8 < 8'd2) begin
      status = ST_BAD_LEN;
    end else if (!frame.enc) begin
      status = (len8 < PLAIN_MIN) ? ST_BAD_LEN : ST_OK;
    end else if (len8 > BUF_LIMIT) begin
      status = ST_BAD_LEN;
    end else begin
      status = frame.hdr_bad ? ST_BAD_HDR : ST_OK;
    end
  end

  assign valid = !frame.enc || (len8 >= ENC_FULL);

  always_comb begin
    result = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.power_state = frame.power;
      result.heater_step = frame.step;
      result.encrypted   = frame.enc;
      if (valid) begin
        result.readings_valid    = 1'b1;
        result.voltage_decivolts = frame.volt;
        result.exhaust_temp      = frame.exh;
        result.ambient_tenths    = frame.enc ? amb_ext : amb_x10;
        result.fault_code        = frame.alt ? frame.err_alt : frame.err_main;
        result.set_point         = frame.target;
        result.gear_setting      = frame.gear;
      end
    end
  end

endmodule

// ===== rtl/heater_status_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// A byte beat accepted into the input register is decoded from there, and the result of a
// final byte is registered in the output register and offered on the output from there.
// Throughput: one byte per cycle, set by the single capture stage behind the input
// register; only a final byte waits, and only while a previous result is unread.
// Reset (rst_n low, synchronous) empties both registers and restarts frame capture.

module heater_status_frame_decoder_unit
  import hsfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 48
) (
  input logic        clk,
  input logic        rst_n,
  hsfd_stream_if.sink   in_ch,
  hsfd_stream_if.source out_ch
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

  logic             in_v_r;
  in_item_t         in_d_r;
  logic             out_v_r;
  out_item_t        out_d_r;
  logic             advance;
  logic             fire;
  logic             in_take;
  frame_state_t     state_nxt;
  logic [CNT_W-1:0] len_nxt;
  out_item_t        result_nxt;

  // Only a final byte needs room in the output register.
  assign advance = !(in_v_r && in_d_r.end_of_frame && out_v_r && !out_ch.ready);
  assign fire    = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  hsfd_capture #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CNT_W(CNT_W)
  ) u_capture (
    .clk(clk),
    .rst_n(rst_n),
    .step_en(fire),
    .frame_byte(in_d_r.frame_byte),
    .end_of_frame(in_d_r.end_of_frame),
    .state_nxt(state_nxt),
    .len_nxt(len_nxt)
  );

  hsfd_format #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CNT_W(CNT_W)
  ) u_format (
    .frame(state_nxt),
    .len(len_nxt),
    .result(result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_d_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && in_d_r.end_of_frame) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_d_r.end_of_frame) begin
      out_d_r <= result_nxt;
    end
  end

endmodule

// ===== bench/tb_heater_status_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_heater_status_frame_decoder_unit;
  import hsfd_pkg::*;

  localparam int FRAME_BUF   = 48;
  localparam int CYCLE_LIMIT = 300000;
  localparam int QUIET_TAIL  = 120;
  localparam int DRAIN_WAIT  = 8;
  // The key repeats every eight bytes; byte 0 of the key sits in the top bits.
  localparam logic [63:0] XOR_KEY = "password";

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count = 0;

  hsfd_stream_if #(.T(in_item_t))  in_bus ();
  hsfd_stream_if #(.T(out_item_t)) out_bus ();

  heater_status_frame_decoder_unit #(
    .BUFFER_BYTES(FRAME_BUF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always #5 clk = ~clk;

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
  end

  // Decoder state as seen by the checker.
  int           rx_count = 0;
  frame_state_t cap = '0;
  out_item_t    expected_reports[$];
  in_item_t     byte_backlog[$];
  int           send_gap = 0;
  int           hold_off = 0;

  function automatic logic [7:0] key_at(int pos);
    return XOR_KEY[(7 - (pos % 8)) * 8 +: 8];
  endfunction

  function automatic logic sync_ok(logic [7:0] b0, logic [7:0] b1);
    return (b0 == HDR0) && ((b1 == HDR1_A) || (b1 == HDR1_B));
  endfunction

  task automatic decode_byte(input in_item_t beat);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d;
    int         pos;
    int         flen;
    int         amb;
    out_item_t  rep;
    pos = rx_count;
    if (pos == POS_FIRST) begin
      cap = '0;
      cap.first_raw = beat.frame_byte;
    end else if (pos == POS_SECOND) begin
      d0 = cap.first_raw;
      d1 = beat.frame_byte;
      cap.enc = !sync_ok(d0, d1);
      if (cap.enc) begin
        d0 = d0 ^ key_at(0);
        d1 = d1 ^ key_at(1);
      end
      cap.hdr_bad = !sync_ok(d0, d1);
      cap.alt = (d1 == HDR1_B);
    end else if (pos <= POS_LAST) begin
      d = cap.enc ? (beat.frame_byte ^ key_at(pos)) : beat.frame_byte;
      case (pos)
        POS_POWER:  cap.power = (d >= 1 && d <= 3) ? d[1:0] : 2'd0;
        POS_ERR:    cap.err_main = d;
        POS_STEP:   cap.step = (d >= 1 && d <= 4) ? d[2:0] : 3'd0;
        POS_TARGET: cap.target = d;
        POS_GEAR:   cap.gear = d;
        default: begin
          if (!cap.enc) begin
            // Plain frames are little endian.
            case (pos)
              POS_VOLT_A:  cap.volt[7:0] = d;
              POS_VOLT_B:  cap.volt[15:8] = d;
              POS_EXH_A:   cap.exh[7:0] = d;
              POS_EXH_B:   cap.exh[15:8] = d;
              POS_AMB_PA:  cap.amb[7:0] = d;
              POS_AMB_PB:  cap.amb[15:8] = d;
              POS_ERR_PLN: cap.err_alt = d;
              default: ;
            endcase
          end else begin
            case (pos)
              POS_VOLT_A:  cap.volt[15:8] = d;
              POS_VOLT_B:  cap.volt[7:0] = d;
              POS_EXH_A:   cap.exh[15:8] = d;
              POS_EXH_B:   cap.exh[7:0] = d;
              POS_AMB_EA:  cap.amb[15:8] = d;
              POS_AMB_EB:  cap.amb[7:0] = d;
              POS_ERR_ENC: cap.err_alt = d;
              default: ;
            endcase
          end
        end
      endcase
    end
    if (pos < FRAME_BUF + 1) rx_count = pos + 1;
    if (!beat.end_of_frame) return;

    flen = rx_count;
    rx_count = 0;
    rep = '0;
    if (flen < 2) rep.status = ST_BAD_LEN;
    else if (!cap.enc) rep.status = (flen < PLAIN_MIN) ? ST_BAD_LEN : ST_OK;
    else if (flen > FRAME_BUF) rep.status = ST_BAD_LEN;
    else rep.status = cap.hdr_bad ? ST_BAD_HDR : ST_OK;

    if (rep.status == ST_OK) begin
      rep.power_state = cap.power;
      rep.heater_step = cap.step;
      rep.encrypted = cap.enc;
      if (!cap.enc || flen >= ENC_FULL) begin
        amb = $signed(cap.amb);
        // Plain frames carry whole degrees.
        if (!cap.enc) amb = amb * 10;
        rep.readings_valid = 1'b1;
        rep.voltage_decivolts = cap.volt;
        rep.exhaust_temp = cap.exh;
        rep.ambient_tenths = amb[19:0];
        rep.fault_code = cap.alt ? cap.err_alt : cap.err_main;
        rep.set_point = cap.target;
        rep.gear_setting = cap.gear;
      end
    end
    expected_reports.push_back(rep);
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      note_mismatch("result with nothing expected, status", '0, got.status);
      return;
    end
    want = expected_reports.pop_front();
    if (got.status !== want.status) note_mismatch("status", want.status, got.status);
    if (got.power_state !== want.power_state)
      note_mismatch("power_state", want.power_state, got.power_state);
    if (got.heater_step !== want.heater_step)
      note_mismatch("heater_step", want.heater_step, got.heater_step);
    if (got.readings_valid !== want.readings_valid)
      note_mismatch("readings_valid", want.readings_valid, got.readings_valid);
    if (got.encrypted !== want.encrypted)
      note_mismatch("encrypted", want.encrypted, got.encrypted);
    if (got.voltage_decivolts !== want.voltage_decivolts)
      note_mismatch("voltage_decivolts", want.voltage_decivolts, got.voltage_decivolts);
    if (got.exhaust_temp !== want.exhaust_temp)
      note_mismatch("exhaust_temp", want.exhaust_temp, got.exhaust_temp);
    if (got.ambient_tenths !== want.ambient_tenths)
      note_mismatch("ambient_tenths", want.ambient_tenths, got.ambient_tenths);
    if (got.fault_code !== want.fault_code)
      note_mismatch("fault_code", want.fault_code, got.fault_code);
    if (got.set_point !== want.set_point)
      note_mismatch("set_point", want.set_point, got.set_point);
    if (got.gear_setting !== want.gear_setting)
      note_mismatch("gear_setting", want.gear_setting, got.gear_setting);
  endtask

  // Byte driver: a beat that is not taken is held until it is.
  always @(posedge clk) begin : drive
    logic     send;
    in_item_t beat;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) decode_byte(in_bus.data);
      send = 1'b0;
      beat = '0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (byte_backlog.size() > 0) begin
        if (byte_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 11);
        end else begin
          beat = byte_backlog.pop_front();
          send = 1'b1;
        end
      end
      in_bus.valid <= send;
      if (send) in_bus.data <= beat;
    end
  end

  always @(posedge clk) begin : watch
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_report(out_bus.data);
      if (hold_off > 0) begin
        hold_off--;
        out_bus.ready <= 1'b0;
      end else if (byte_backlog.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        hold_off = $urandom_range(0, 11);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Random frame with a plain header; power and step bytes lean toward known codes.
  function automatic byte_q_t make_frame(int len, bit alt);
    byte_q_t f;
    for (int i = 0; i < len; i++) f.push_back(8'($urandom_range(0, 255)));
    if (len > 0) f[0] = HDR0;
    if (len > 1) f[1] = alt ? HDR1_B : HDR1_A;
    if (len > POS_POWER && $urandom_range(0, 3) != 0) f[POS_POWER] = 8'($urandom_range(0, 4));
    if (len > POS_STEP && $urandom_range(0, 3) != 0) f[POS_STEP] = 8'($urandom_range(0, 5));
    return f;
  endfunction

  function automatic byte_q_t scramble(byte_q_t f);
    foreach (f[i]) f[i] = f[i] ^ key_at(i);
    return f;
  endfunction

  task automatic send_frame(byte_q_t f);
    in_item_t beat;
    foreach (f[i]) begin
      beat.frame_byte = f[i];
      beat.end_of_frame = (i == f.size() - 1);
      byte_backlog.push_back(beat);
    end
  endtask

  initial begin : stimulus
    byte_q_t f;
    int      pick;
    int      len;
    int      frames;

    // Directed frames.
    send_frame(make_frame(1, 1'b0));
    send_frame(make_frame(2, 1'b0));
    send_frame(make_frame(17, 1'b1));
    f = make_frame(18, 1'b0);
    foreach (f[i]) if (i > 1) f[i] = 8'hFF;
    f[POS_POWER] = 8'd3;
    f[POS_STEP] = 8'd4;
    send_frame(f);
    // Most negative ambient, unknown power and step codes, fault from the late byte.
    f = make_frame(18, 1'b1);
    f[POS_AMB_PA] = 8'h00;
    f[POS_AMB_PB] = 8'h80;
    f[POS_POWER] = 8'hFF;
    f[POS_STEP] = 8'd5;
    send_frame(f);
    f = make_frame(40, 1'b0);
    f[POS_AMB_PA] = 8'hFF;
    f[POS_AMB_PB] = 8'h7F;
    f[POS_POWER] = 8'd0;
    f[POS_STEP] = 8'd0;
    send_frame(f);
    send_frame(scramble(make_frame(2, 1'b0)));
    send_frame(scramble(make_frame(35, 1'b1)));
    f = make_frame(36, 1'b1);
    f[POS_AMB_EA] = 8'h80;
    f[POS_AMB_EB] = 8'h00;
    send_frame(scramble(f));
    send_frame(scramble(make_frame(FRAME_BUF, 1'b0)));
    send_frame(scramble(make_frame(FRAME_BUF + 1, 1'b0)));
    send_frame(scramble(make_frame(64, 1'b1)));
    // A raw 0xAA that is not followed by a valid second byte is taken as encrypted.
    f = make_frame(36, 1'b0);
    f[1] = 8'h00;
    send_frame(f);
    f = make_frame(20, 1'b0);
    foreach (f[i]) f[i] = 8'h00;
    send_frame(f);

    frames = 0;
    while (byte_backlog.size() < 900 || frames < 40) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        pick = $urandom_range(0, 9);
        len = (pick < 7) ? $urandom_range(18, 24) :
              (pick < 9) ? $urandom_range(25, 64) : $urandom_range(2, 17);
        send_frame(make_frame(len, $urandom_range(0, 1)));
      end else if (pick < 8) begin
        pick = $urandom_range(0, 9);
        len = (pick < 5) ? $urandom_range(ENC_FULL, FRAME_BUF) :
              (pick < 8) ? $urandom_range(2, ENC_FULL - 1) : $urandom_range(FRAME_BUF + 1, 64);
        send_frame(scramble(make_frame(len, $urandom_range(0, 1))));
      end else if (pick < 9) begin
        // Encrypted frame whose header stays wrong after decoding.
        f = scramble(make_frame($urandom_range(ENC_FULL, FRAME_BUF), $urandom_range(0, 1)));
        do begin
          f[0] = $urandom_range(0, 1) ? (HDR0 ^ key_at(0)) : 8'($urandom_range(0, 255));
          f[1] = 8'($urandom_range(0, 255));
        end while (sync_ok(f[0], f[1]) || sync_ok(f[0] ^ key_at(0), f[1] ^ key_at(1)));
        send_frame(f);
      end else begin
        f = {};
        len = $urandom_range(1, 64);
        for (int i = 0; i < len; i++) f.push_back(8'($urandom_range(0, 255)));
        send_frame(f);
      end
      frames++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || in_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_reports.size() != 0)
      note_mismatch("results never delivered", expected_reports.size(), '0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
